>>> sv/countdown_timer_seven_segment_assert.svh
// ----------------------------------------------------------------------------
// Countdown timer assertion macros
// Concurrent assertion helpers shared by the countdown timer RTL.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_SEVEN_SEGMENT_ASSERT_SVH
`define COUNTDOWN_TIMER_SEVEN_SEGMENT_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define CTSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("countdown timer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CTSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("countdown timer assertion failed");

`else

`define CTSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define CTSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/ctss_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer package
// Types, constants and decode functions shared by the countdown timer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctss_pkg;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_TOGGLE  = 3'd1,
      CMD_SET_CS  = 3'd2,
      CMD_SET_SEC = 3'd3,
      CMD_SET_MIN = 3'd4
   } cmd_type;

   localparam logic [6:0] MAX_CS_FIELD = 7'd99;
   localparam logic [6:0] MAX_SM_FIELD = 7'd59;
   localparam logic [18:0] MAX_TIME    = 19'd359999;

   // Time held as decimal digits, MM:SS.CC.
   typedef struct packed {
      logic [2:0] min_tens;
      logic [3:0] min_ones;
      logic [2:0] sec_tens;
      logic [3:0] sec_ones;
      logic [3:0] cs_tens;
      logic [3:0] cs_ones;
   } digits_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } pair_type;

   typedef struct packed {
      logic [18:0] time_centis;
      logic        is_running;
      logic [15:0] minutes_segments;
      logic [31:0] seconds_centis_segments;
   } rsp_type;

   // Active-high segment pattern, gfedcba.
   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   // Splits a value up to 99 into two decimal digits (tens by reciprocal).
   function automatic pair_type split_pair(input logic [6:0] v);
      logic [13:0] prod;
      pair_type    p;
      prod   = 14'(v) * 14'd103;
      p.tens = prod[13:10];
      p.ones = 4'(v - 7'(p.tens) * 7'd10);
      return p;
   endfunction

   function automatic logic [18:0] time_of(input digits_type d);
      return 19'(d.min_tens) * 19'd60000 + 19'(d.min_ones) * 19'd6000
           + 19'(d.sec_tens) * 19'd1000  + 19'(d.sec_ones) * 19'd100
           + 19'(d.cs_tens)  * 19'd10    + 19'(d.cs_ones);
   endfunction

endpackage

`default_nettype wire

>>> sv/ctss_next.sv
// ----------------------------------------------------------------------------
// Countdown timer next state
// Applies one command to the digit state and the run flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ctss_next (
   input  ctss_pkg::digits_type digits,
   input  logic                 run,
   input  ctss_pkg::cmd_type    command,
   input  logic [7:0]           switch_value,
   output ctss_pkg::digits_type digits_next,
   output logic                 run_next
);

   logic [6:0]         cs_clamp;
   logic [6:0]         sm_clamp;
   ctss_pkg::pair_type cs_pair;
   ctss_pkg::pair_type sm_pair;

   assign cs_clamp = (switch_value > 8'(ctss_pkg::MAX_CS_FIELD)) ?
                     ctss_pkg::MAX_CS_FIELD : switch_value[6:0];
   assign sm_clamp = (switch_value > 8'(ctss_pkg::MAX_SM_FIELD)) ?
                     ctss_pkg::MAX_SM_FIELD : switch_value[6:0];
   assign cs_pair  = ctss_pkg::split_pair(cs_clamp);
   assign sm_pair  = ctss_pkg::split_pair(sm_clamp);

   always_comb begin
      digits_next = digits;
      run_next    = run;
      case (command)
         ctss_pkg::CMD_TICK: begin
            // Borrow ripples up through the digits; a nonzero time always
            // stops the ripple somewhere.
            if (run && (digits != '0)) begin
               if (digits.cs_ones != 4'd0) begin
                  digits_next.cs_ones = digits.cs_ones - 4'd1;
               end else begin
                  digits_next.cs_ones = 4'd9;
                  if (digits.cs_tens != 4'd0) begin
                     digits_next.cs_tens = digits.cs_tens - 4'd1;
                  end else begin
                     digits_next.cs_tens = 4'd9;
                     if (digits.sec_ones != 4'd0) begin
                        digits_next.sec_ones = digits.sec_ones - 4'd1;
                     end else begin
                        digits_next.sec_ones = 4'd9;
                        if (digits.sec_tens != 3'd0) begin
                           digits_next.sec_tens = digits.sec_tens - 3'd1;
                        end else begin
                           digits_next.sec_tens = 3'd5;
                           if (digits.min_ones != 4'd0) begin
                              digits_next.min_ones = digits.min_ones - 4'd1;
                           end else begin
                              digits_next.min_ones = 4'd9;
                              digits_next.min_tens = digits.min_tens - 3'd1;
                           end
                        end
                     end
                  end
               end
            end
         end
         ctss_pkg::CMD_TOGGLE: begin
            run_next = !run;
         end
         ctss_pkg::CMD_SET_CS: begin
            digits_next.cs_tens = cs_pair.tens;
            digits_next.cs_ones = cs_pair.ones;
         end
         ctss_pkg::CMD_SET_SEC: begin
            digits_next.sec_tens = sm_pair.tens[2:0];
            digits_next.sec_ones = sm_pair.ones;
         end
         ctss_pkg::CMD_SET_MIN: begin
            digits_next.min_tens = sm_pair.tens[2:0];
            digits_next.min_ones = sm_pair.ones;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/countdown_timer_seven_segment.sv
// ----------------------------------------------------------------------------
// Countdown timer with seven-segment display
// MM:SS.CC countdown timer that returns refreshed digit patterns per request.
// ----------------------------------------------------------------------------
// Each request carries a command (tick, toggle run, set centiseconds, set
// seconds, set minutes) and a switch value, and produces exactly one response
// with six active-high segment bytes, the run flag and the remaining time in
// centiseconds. Ticks count down only while running and hold at 00:00.00.
// Set values above the field maximum saturate to 99 or 59. Unused command
// codes leave the state alone. While the skid register is empty one request
// is accepted every clock cycle and its response is registered; the rate is
// set by the time and run flag registers, which feed back into the next-state
// logic once per cycle. A two-entry output buffer takes one more request while
// a response is stalled. Reset clears the time to zero and stops the timer.
`default_nettype none

`include "countdown_timer_seven_segment_assert.svh"

module countdown_timer_seven_segment (
   input  logic        clock,
   input  logic        reset,
   // req_tuser: [2:0] command
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] switch_value
   input  logic [2:0]  req_tuser,
   // rsp_tdata: [31:0] seconds_centis_segments, [47:32] minutes_segments,
   //            [48] is_running, [67:49] time_centis, [71:68] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata
);

   // Time state is kept as decimal digits so the display needs no divider.
   ctss_pkg::digits_type digits_ff;
   ctss_pkg::digits_type digits_in;
   logic                 run_ff;
   logic                 run_in;

   ctss_pkg::rsp_type    result_in;
   ctss_pkg::rsp_type    out_ff;
   ctss_pkg::rsp_type    skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;

   logic                 req_acc;
   logic                 rsp_pop;
   logic                 toggle_acc;

   assign req_tready = !skid_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_pop    = out_valid_ff && rsp_tready;
   assign toggle_acc = req_acc && (req_tuser == ctss_pkg::CMD_TOGGLE);

   ctss_next u_next (
      .digits       (digits_ff),
      .run          (run_ff),
      .command      (ctss_pkg::cmd_type'(req_tuser)),
      .switch_value (req_tdata),
      .digits_next  (digits_in),
      .run_next     (run_in)
   );

   // The response reflects the state after this request.
   always_comb begin
      result_in.time_centis = ctss_pkg::time_of(digits_in);
      result_in.is_running  = run_in;
      result_in.minutes_segments = {
         ctss_pkg::seg_of({1'b0, digits_in.min_tens}),
         ctss_pkg::seg_of(digits_in.min_ones)
      };
      result_in.seconds_centis_segments = {
         ctss_pkg::seg_of({1'b0, digits_in.sec_tens}),
         ctss_pkg::seg_of(digits_in.sec_ones),
         ctss_pkg::seg_of(digits_in.cs_tens),
         ctss_pkg::seg_of(digits_in.cs_ones)
      };
   end

   // Timer state updates on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= '0;
         run_ff    <= 1'b0;
      end else if (req_acc) begin
         digits_ff <= digits_in;
         run_ff    <= run_in;
      end
   end

   // Output buffer control. A response goes straight to the output register
   // when it is free or draining, otherwise into the skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_acc) begin
         if (!out_valid_ff || rsp_pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output buffer payload.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_ff <= skid_ff;
         end
      end else if (req_acc) begin
         if (!out_valid_ff || rsp_pop) begin
            out_ff <= result_in;
         end else begin
            skid_ff <= result_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff};

   // The skid register is only ever filled behind a held output register.
   `CTSS_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // A request taken while the output stalls must land in the skid register.
   `CTSS_ASSERT_NEXT(a_stall_to_skid, clock, reset, req_acc && out_valid_ff && !rsp_tready, skid_valid_ff)
   // The reported time never exceeds 59:59.99.
   `CTSS_ASSERT_SAME(a_time_range, clock, reset, out_valid_ff, out_ff.time_centis <= ctss_pkg::MAX_TIME)
   // A toggle request flips the run flag.
   `CTSS_ASSERT_NEXT(a_toggle_flips, clock, reset, toggle_acc, run_ff != $past(run_ff))

endmodule

`default_nettype wire

>>> dv/countdown_timer_seven_segment_tb.sv
// ----------------------------------------------------------------------------
// Countdown timer with seven-segment display: testbench
// Drives tick, toggle, set and spare commands through the request stream in
// bursts, stalls the response stream, and checks each response field by field
// against a cycle-free model of the remaining time and run flag.
// ----------------------------------------------------------------------------
module countdown_timer_seven_segment_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Command codes the block leaves unused; they must not change the state.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam int CENTIS_PER_SECOND = 100;
   localparam int CENTIS_PER_MINUTE = 6000;
   localparam int RANDOM_REQUESTS   = 1550;
   localparam int DRAIN_CYCLES      = 8;

   // Keeps its own copy of the remaining time and the run flag, predicts the
   // response of every accepted request and matches responses in order.
   class time_scoreboard;
      int unsigned       centis_left;
      bit                running;
      ctss_pkg::rsp_type pending_q[$];
      int                errors;
      int                checked;

      function new();
         centis_left = 0;
         running     = 1'b0;
         errors      = 0;
         checked     = 0;
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction

      function logic [7:0] glyph(input int unsigned digit);
         case (digit)
            0:       return 8'h3F;
            1:       return 8'h06;
            2:       return 8'h5B;
            3:       return 8'h4F;
            4:       return 8'h66;
            5:       return 8'h6D;
            6:       return 8'h7D;
            7:       return 8'h07;
            8:       return 8'h7F;
            default: return 8'h6F;
         endcase
      endfunction

      function logic [15:0] two_glyphs(input int unsigned value);
         return {glyph((value / 10) % 10), glyph(value % 10)};
      endfunction

      function void note_request(input logic [2:0] cmd, input logic [7:0] sw);
         int unsigned       t;
         int unsigned       field;
         ctss_pkg::rsp_type want;
         t = centis_left;
         case (cmd)
            ctss_pkg::CMD_TICK: begin
               if (running && t != 0) t = t - 1;
            end
            ctss_pkg::CMD_TOGGLE: begin
               running = !running;
            end
            ctss_pkg::CMD_SET_CS: begin
               field = (sw > ctss_pkg::MAX_CS_FIELD) ? ctss_pkg::MAX_CS_FIELD : sw;
               t = t - (t % CENTIS_PER_SECOND) + field;
            end
            ctss_pkg::CMD_SET_SEC: begin
               field = (sw > ctss_pkg::MAX_SM_FIELD) ? ctss_pkg::MAX_SM_FIELD : sw;
               t = t - (t % CENTIS_PER_MINUTE) + field * CENTIS_PER_SECOND
                 + (t % CENTIS_PER_SECOND);
            end
            ctss_pkg::CMD_SET_MIN: begin
               field = (sw > ctss_pkg::MAX_SM_FIELD) ? ctss_pkg::MAX_SM_FIELD : sw;
               t = (t % CENTIS_PER_MINUTE) + field * CENTIS_PER_MINUTE;
            end
            default: begin
            end
         endcase
         if (t > ctss_pkg::MAX_TIME) t = ctss_pkg::MAX_TIME;
         centis_left = t;
         want.time_centis      = 19'(t);
         want.is_running       = running;
         want.minutes_segments = two_glyphs(t / CENTIS_PER_MINUTE);
         want.seconds_centis_segments =
            {two_glyphs((t % CENTIS_PER_MINUTE) / CENTIS_PER_SECOND),
             two_glyphs(t % CENTIS_PER_SECOND)};
         pending_q.push_back(want);
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         $display("[%0t] mismatch on response %0d: %s got 0x%0h, expected 0x%0h",
                  $realtime, checked, what, got, want);
         errors++;
      endtask

      task check_response(input logic [71:0] data);
         ctss_pkg::rsp_type got;
         ctss_pkg::rsp_type want;
         got = data[67:0];
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected response, time_centis",
                            32'(got.time_centis), 32'h0);
            return;
         end
         want = pending_q.pop_front();
         if (got.seconds_centis_segments !== want.seconds_centis_segments)
            report_mismatch("seconds_centis_segments",
                            got.seconds_centis_segments,
                            want.seconds_centis_segments);
         if (got.minutes_segments !== want.minutes_segments)
            report_mismatch("minutes_segments", 32'(got.minutes_segments),
                            32'(want.minutes_segments));
         if (got.is_running !== want.is_running)
            report_mismatch("is_running", 32'(got.is_running),
                            32'(want.is_running));
         if (got.time_centis !== want.time_centis)
            report_mismatch("time_centis", 32'(got.time_centis),
                            32'(want.time_centis));
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] switch_value
   logic [2:0]  req_tuser;    // [2:0] command
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [31:0] seconds_centis_segments,
                              // [47:32] minutes_segments, [48] is_running,
                              // [67:49] time_centis, [71:68] zero

   time_scoreboard sb;
   int             burst_left;
   int             requests_sent;

   countdown_timer_seven_segment u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The clock starts low, so the first rising edge falls at 2 ns.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Sends one request. The sender works in bursts: once a burst is used up,
   // the valid drops for a random gap (sometimes none) before the next burst.
   // Inputs change only at the falling edge; the handshake is sampled at the
   // rising edge, where the request is handed to the scoreboard.
   task automatic issue(input logic [2:0] cmd, input logic [7:0] sw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = sw;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, sw);
      requests_sent++;
      @(negedge clock);
   endtask

   // Holds the sender off until every outstanding response has come back.
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // A typical use of the timer: program a time, start it, let it count for a
   // while and usually stop it again. Small minute and centisecond values, and
   // whole seconds or minutes now and then, make the decrement borrow across
   // the field boundaries and reach zero while running.
   task automatic run_countdown();
      int ticks;
      int i;
      issue(ctss_pkg::CMD_SET_MIN,
            ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 2)));
      issue(ctss_pkg::CMD_SET_SEC,
            ($urandom_range(0, 3) == 0) ? 8'h00
                                        : 8'($urandom_range(0, 255)));
      issue(ctss_pkg::CMD_SET_CS,
            ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 5))
                                        : 8'($urandom_range(0, 255)));
      if (!sb.running) issue(ctss_pkg::CMD_TOGGLE, 8'($urandom_range(0, 255)));
      ticks = $urandom_range(5, 120);
      for (i = 0; i < ticks; i++) begin
         // A pause and resume in the middle of the run now and then.
         if ($urandom_range(0, 39) == 0)
            issue(ctss_pkg::CMD_TOGGLE, 8'($urandom_range(0, 255)));
         issue(ctss_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) != 0)
         issue(ctss_pkg::CMD_TOGGLE, 8'($urandom_range(0, 255)));
   endtask

   // One request of any kind, including the spare command codes and switch
   // values far above the field maxima.
   task automatic random_request();
      int       pick;
      logic [2:0] cmd;
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = ctss_pkg::CMD_TICK;
      else if (pick < 55) cmd = ctss_pkg::CMD_TOGGLE;
      else if (pick < 67) cmd = ctss_pkg::CMD_SET_CS;
      else if (pick < 79) cmd = ctss_pkg::CMD_SET_SEC;
      else if (pick < 91) cmd = ctss_pkg::CMD_SET_MIN;
      else                cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      issue(cmd, 8'($urandom_range(0, 255)));
   endtask

   // The receiver stalls on a pattern of its own: stretches of steady
   // readiness, coin-flip stalls, mostly-ready stretches and sparse stretches
   // that are ready when the count left is a multiple of six, each of random length.
   initial begin
      int mode;
      int left;
      rsp_tready = 1'b0;
      left = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(4, 40);
         end
         left--;
         case (mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = 1'($urandom_range(0, 1));
            2:       rsp_tready = ($urandom_range(0, 3) != 0);
            default: rsp_tready = (left % 6 == 0);
         endcase
      end
   end

   // Responses are taken at the rising edge where valid and ready meet.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Main stimulus: reset, a directed walk through the special cases, then
   // random traffic made mostly of complete countdown runs.
   initial begin
      int c;
      sb            = new();
      burst_left    = 0;
      requests_sent = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = ctss_pkg::CMD_TICK;
      req_tdata     = 8'h00;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Tick while stopped at zero, then the spare codes, which change nothing.
      issue(ctss_pkg::CMD_TICK, 8'hFF);
      for (c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) issue(3'(c), 8'hA5);
      // Running at zero: the time holds and the run flag stays set.
      issue(ctss_pkg::CMD_TOGGLE, 8'h00);
      issue(ctss_pkg::CMD_TICK, 8'h00);
      // Switch values above the field maxima saturate, giving 59:59.99.
      issue(ctss_pkg::CMD_SET_CS, 8'hFF);
      issue(ctss_pkg::CMD_SET_SEC, 8'hFF);
      issue(ctss_pkg::CMD_SET_MIN, 8'hFF);
      issue(ctss_pkg::CMD_TICK, 8'h5A);
      // Just above each maximum.
      issue(ctss_pkg::CMD_SET_CS, 8'd100);
      issue(ctss_pkg::CMD_SET_SEC, 8'd60);
      issue(ctss_pkg::CMD_SET_MIN, 8'd60);
      // 1:00.00 minus one centisecond borrows through both lower fields.
      issue(ctss_pkg::CMD_SET_CS, 8'd0);
      issue(ctss_pkg::CMD_SET_SEC, 8'd0);
      issue(ctss_pkg::CMD_SET_MIN, 8'd1);
      issue(ctss_pkg::CMD_TICK, 8'h00);
      // A whole second borrows from the seconds field only.
      issue(ctss_pkg::CMD_SET_CS, 8'd0);
      issue(ctss_pkg::CMD_TICK, 8'h00);
      // Stopped again: ticks leave the time alone.
      issue(ctss_pkg::CMD_TOGGLE, 8'hFF);
      issue(ctss_pkg::CMD_TICK, 8'h00);
      // Count the last centisecond down to zero, where the time holds.
      issue(ctss_pkg::CMD_SET_MIN, 8'd0);
      issue(ctss_pkg::CMD_SET_SEC, 8'd0);
      issue(ctss_pkg::CMD_SET_CS, 8'd1);
      issue(ctss_pkg::CMD_TOGGLE, 8'h00);
      issue(ctss_pkg::CMD_TICK, 8'h00);
      issue(ctss_pkg::CMD_TICK, 8'h00);
      issue(ctss_pkg::CMD_TOGGLE, 8'h00);

      // Let every response of the directed part come back before going on.
      drain();

      while (requests_sent < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 9) < 7) run_countdown();
         else repeat ($urandom_range(1, 12)) random_request();
         // Hold the sender off from time to time until the pipe is empty.
         if ($urandom_range(0, 24) == 0) drain();
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("PASS countdown_timer_seven_segment");
      end else begin
         $display("FAIL countdown_timer_seven_segment");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #1000000;
      $display("FAIL countdown_timer_seven_segment");
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/ctss_pkg.sv
sv/ctss_next.sv
sv/countdown_timer_seven_segment.sv
dv/countdown_timer_seven_segment_tb.sv
